// ----- rtl/tte_pkg.sv -----
// ----------------------------------------------------------------------------
// Taylor table evaluator package
// Shared constants, command codes and pipeline types.
// ----------------------------------------------------------------------------
package tte_pkg;

   localparam int NX_POINTS      = 32;
   localparam int NY_POINTS      = 32;
   localparam int NUM_PROPERTIES = 5;
   localparam int FRAC_BITS      = 16;

   localparam int X_BITS     = $clog2(NX_POINTS);
   localparam int Y_BITS     = $clog2(NY_POINTS);
   localparam int P_BITS     = (NUM_PROPERTIES > 1) ? $clog2(NUM_PROPERTIES) : 1;
   localparam int DEPTH      = NX_POINTS * NY_POINTS * NUM_PROPERTIES;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int NUM_COEFFS = 6;

   typedef enum logic [2:0] {
      CMD_WRITE_COEFF = 3'd0,
      CMD_WRITE_X     = 3'd1,
      CMD_WRITE_Y     = 3'd2,
      CMD_VALUE       = 3'd3,
      CMD_DDX         = 3'd4,
      CMD_DDY         = 3'd5
   } command_type;

   localparam logic [1:0] KIND_PROPERTY = 2'd0;
   localparam logic [1:0] KIND_X_KEY    = 2'd1;
   localparam logic [1:0] KIND_Y_KEY    = 2'd2;

   localparam logic [2:0] COEFF_Z   = 3'd0;
   localparam logic [2:0] COEFF_DX  = 3'd1;
   localparam logic [2:0] COEFF_DY  = 3'd2;
   localparam logic [2:0] COEFF_DXX = 3'd3;
   localparam logic [2:0] COEFF_DYY = 3'd4;
   localparam logic [2:0] COEFF_DXY = 3'd5;

   localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

   typedef struct packed {
      logic [2:0]         command;
      logic [4:0]         x_index;
      logic [4:0]         y_index;
      logic [2:0]         property_select;
      logic [2:0]         coeff_select;
      logic signed [31:0] write_data;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic [1:0]         output_kind;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               saturated;
   } rsp_type;

   // Control that travels with an item from the store to the arithmetic.
   typedef struct packed {
      logic       eval;      // full Taylor evaluation
      logic [2:0] command;
      logic       fixed_one; // key derivative equal to one
   } ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                output logic flag);
      logic signed [65:0] mx;
      logic signed [65:0] mn;
      begin
         mx = 66'sd2147483647;
         mn = -66'sd2147483648;
         flag = 1'b0;
         if (v > mx) begin
            flag = 1'b1;
            sat32 = 32'sh7fffffff;
         end else if (v < mn) begin
            flag = 1'b1;
            sat32 = 32'sh80000000;
         end else begin
            sat32 = v[31:0];
         end
      end
   endfunction

endpackage

// ----- rtl/tte_stream_if.sv -----
// ----------------------------------------------------------------------------
// Taylor table evaluator stream interface
// Valid/ready channel that carries one payload item.
// ----------------------------------------------------------------------------
interface tte_stream_if #(type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/tte_store.sv -----
// ----------------------------------------------------------------------------
// Taylor table coefficient store
// Six coefficient memories and two node coordinate memories, read with
// registered data.
// ----------------------------------------------------------------------------
module tte_store (
   input  logic                           clock,
   input  logic                           wr_coeff_en,
   input  logic [2:0]                     wr_coeff_sel,
   input  logic [tte_pkg::ADDR_BITS-1:0]  wr_addr,
   input  logic                           wr_x_en,
   input  logic                           wr_y_en,
   input  logic [tte_pkg::X_BITS-1:0]     wr_x_addr,
   input  logic [tte_pkg::Y_BITS-1:0]     wr_y_addr,
   input  logic signed [31:0]             wr_data,
   input  logic                           rd_en,
   input  logic [tte_pkg::ADDR_BITS-1:0]  rd_addr,
   input  logic [tte_pkg::X_BITS-1:0]     rd_x_addr,
   input  logic [tte_pkg::Y_BITS-1:0]     rd_y_addr,
   output logic signed [31:0]             rd_coeff [tte_pkg::NUM_COEFFS],
   output logic signed [31:0]             rd_x_node,
   output logic signed [31:0]             rd_y_node
);

   logic signed [31:0] coeff_mem [tte_pkg::NUM_COEFFS][tte_pkg::DEPTH];
   logic signed [31:0] x_mem [tte_pkg::NX_POINTS];
   logic signed [31:0] y_mem [tte_pkg::NY_POINTS];

   for (genvar k = 0; k < tte_pkg::NUM_COEFFS; k++) begin : g_bank
      always_ff @(posedge clock) begin
         if (wr_coeff_en && wr_coeff_sel == 3'(k)) begin
            coeff_mem[k][wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_coeff[k] <= coeff_mem[k][rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_x_en) begin
         x_mem[wr_x_addr] <= wr_data;
      end
      if (wr_y_en) begin
         y_mem[wr_y_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_x_node <= x_mem[rd_x_addr];
         rd_y_node <= y_mem[rd_y_addr];
      end
   end

endmodule

// ----- rtl/tte_datapath.sv -----
// ----------------------------------------------------------------------------
// Taylor table arithmetic pipeline
// Deltas, squared terms, coefficient products and the saturated sum over
// four registered stages that all hold while the output stalls.
// ----------------------------------------------------------------------------
module tte_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  tte_pkg::ctl_type     in_ctl,
   input  logic signed [31:0]   x_value,
   input  logic signed [31:0]   y_value,
   input  logic signed [31:0]   coeff [tte_pkg::NUM_COEFFS],
   input  logic signed [31:0]   x_node,
   input  logic signed [31:0]   y_node,
   output logic                 out_valid,
   output tte_pkg::rsp_type     out_rsp
);

   localparam int F = tte_pkg::FRAC_BITS;

   // Stage A: deltas.
   logic                 a_valid_ff;
   tte_pkg::ctl_type     a_ctl_ff;
   logic signed [31:0]   a_dx_ff, a_dy_ff;
   logic                 a_flag_ff;
   logic signed [31:0]   a_c_ff [tte_pkg::NUM_COEFFS];
   logic signed [31:0]   a_dx_in, a_dy_in;
   logic                 fdx, fdy;

   // Stage B: squares and first-order products.
   logic                 b_valid_ff;
   tte_pkg::ctl_type     b_ctl_ff;
   logic signed [31:0]   b_sxx_ff, b_syy_ff, b_sxy_ff;
   logic signed [31:0]   b_dx_ff, b_dy_ff;
   logic signed [63:0]   b_p1_ff, b_p2_ff;
   logic                 b_flag_ff;
   logic signed [31:0]   b_c_ff [tte_pkg::NUM_COEFFS];
   logic signed [31:0]   b_sxx_in, b_syy_in, b_sxy_in;
   logic                 fxx, fyy, fxy;
   logic signed [63:0]   sq_xx, sq_yy, sq_xy;

   // Stage C: second-order products.
   logic                 c_valid_ff;
   tte_pkg::ctl_type     c_ctl_ff;
   logic signed [63:0]   c_p1_ff, c_p2_ff, c_p3_ff, c_p4_ff, c_p5_ff;
   logic signed [31:0]   c_c0_ff, c_c1_ff, c_c2_ff;
   logic                 c_flag_ff;

   // Stage D: result.
   logic                 d_valid_ff;
   tte_pkg::rsp_type     d_rsp_ff;
   tte_pkg::rsp_type     d_rsp_in;
   logic signed [65:0]   sum;
   logic                 fsum;

   always_comb begin
      a_dx_in = tte_pkg::sat32(66'(x_value) - 66'(x_node), fdx);
      a_dy_in = tte_pkg::sat32(66'(y_value) - 66'(y_node), fdy);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ctl_ff  <= in_ctl;
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;
         a_flag_ff <= in_ctl.eval && (fdx || fdy);
         a_c_ff    <= coeff;
      end
   end

   always_comb begin
      sq_xx = a_dx_ff * a_dx_ff;
      sq_yy = a_dy_ff * a_dy_ff;
      sq_xy = a_dx_ff * a_dy_ff;
      b_sxx_in = tte_pkg::sat32(66'(sq_xx >>> (F + 1)), fxx);
      b_syy_in = tte_pkg::sat32(66'(sq_yy >>> (F + 1)), fyy);
      b_sxy_in = tte_pkg::sat32(66'(sq_xy >>> F), fxy);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_ctl_ff <= a_ctl_ff;
         b_sxx_ff <= b_sxx_in;
         b_syy_ff <= b_syy_in;
         b_sxy_ff <= b_sxy_in;
         b_dx_ff  <= a_dx_ff;
         b_dy_ff  <= a_dy_ff;
         b_c_ff   <= a_c_ff;
         b_flag_ff <= a_flag_ff ||
                      (a_ctl_ff.eval && a_ctl_ff.command == tte_pkg::CMD_VALUE &&
                       (fxx || fyy || fxy));
         b_p1_ff  <= a_dx_ff * a_c_ff[tte_pkg::COEFF_DX];
         b_p2_ff  <= a_dy_ff * a_c_ff[tte_pkg::COEFF_DY];
      end
   end

   // Stage C picks operands per command; p1/p2 are the value path's first terms.
   always_ff @(posedge clock) begin
      if (advance) begin
         c_ctl_ff  <= b_ctl_ff;
         c_flag_ff <= b_flag_ff;
         c_c0_ff   <= b_c_ff[tte_pkg::COEFF_Z];
         c_c1_ff   <= b_c_ff[tte_pkg::COEFF_DX];
         c_c2_ff   <= b_c_ff[tte_pkg::COEFF_DY];
         c_p1_ff   <= b_p1_ff;
         c_p2_ff   <= b_p2_ff;
         case (b_ctl_ff.command)
            tte_pkg::CMD_DDX: begin
               c_p3_ff <= b_dx_ff * b_c_ff[tte_pkg::COEFF_DXX];
               c_p4_ff <= b_dy_ff * b_c_ff[tte_pkg::COEFF_DXY];
               c_p5_ff <= '0;
            end
            tte_pkg::CMD_DDY: begin
               c_p3_ff <= b_dy_ff * b_c_ff[tte_pkg::COEFF_DYY];
               c_p4_ff <= b_dx_ff * b_c_ff[tte_pkg::COEFF_DXY];
               c_p5_ff <= '0;
            end
            default: begin
               c_p3_ff <= b_sxx_ff * b_c_ff[tte_pkg::COEFF_DXX];
               c_p4_ff <= b_syy_ff * b_c_ff[tte_pkg::COEFF_DYY];
               c_p5_ff <= b_sxy_ff * b_c_ff[tte_pkg::COEFF_DXY];
            end
         endcase
      end
   end

   always_comb begin
      case (c_ctl_ff.command)
         tte_pkg::CMD_DDX: begin
            sum = 66'(c_c1_ff) + 66'(c_p3_ff >>> F) + 66'(c_p4_ff >>> F);
         end
         tte_pkg::CMD_DDY: begin
            sum = 66'(c_c2_ff) + 66'(c_p3_ff >>> F) + 66'(c_p4_ff >>> F);
         end
         default: begin
            sum = 66'(c_c0_ff) + 66'(c_p1_ff >>> F) + 66'(c_p2_ff >>> F)
                + 66'(c_p3_ff >>> F) + 66'(c_p4_ff >>> F) + 66'(c_p5_ff >>> F);
         end
      endcase
      d_rsp_in.result_value = tte_pkg::sat32(sum, fsum);
      d_rsp_in.saturated    = c_flag_ff || fsum;
      if (!c_ctl_ff.eval) begin
         d_rsp_in.result_value = c_ctl_ff.fixed_one ? tte_pkg::ONE_Q : 32'sd0;
         d_rsp_in.saturated    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_rsp_ff <= d_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_rsp   = d_rsp_ff;

endmodule

// ----- rtl/taylor_table_evaluator.sv -----
// ----------------------------------------------------------------------------
// Taylor table evaluator
// Second-order Taylor lookups on a grid of stored coefficients.
// ----------------------------------------------------------------------------
// Items enter on the req channel and leave on the rsp channel, both
// valid/ready. Each item gives exactly one response: writes answer zero.
// Coefficient and node coordinate writes go straight into the memories.
// Evaluations read all six coefficient memories and both coordinate
// memories at once, then pass through four arithmetic stages to the
// response. One item is accepted every cycle while the receiver does not
// stall; the rate is set by the single read port of each memory.
// A read that follows a write to the same entry sees the new data, since
// the write lands before the next cycle's read.
// When the receiver stalls, the whole pipeline holds and req_ready drops
// while a response waits. Reset empties the pipeline; memory contents
// are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
module taylor_table_evaluator (
   input logic        clock,
   input logic        reset,
   tte_stream_if.sink   req,
   tte_stream_if.source rsp
);

   tte_pkg::req_type                r;
   logic                            advance;
   logic                            accept;
   logic                            x_ok, y_ok, p_ok, ok;
   logic [tte_pkg::ADDR_BITS-1:0]   addr;
   logic [tte_pkg::X_BITS-1:0]      xi;
   logic [tte_pkg::Y_BITS-1:0]      yi;
   tte_pkg::ctl_type                ctl_in;
   tte_pkg::ctl_type                m_ctl_ff;
   logic                            m_valid_ff;
   logic signed [31:0]              m_xv_ff, m_yv_ff;
   logic signed [31:0]              rd_coeff [tte_pkg::NUM_COEFFS];
   logic signed [31:0]              rd_x_node, rd_y_node;
   logic                            is_eval, key_one, key_zero;
   logic                            dp_valid;

   assign r       = req.payload;
   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;
   assign accept  = req.valid && advance;

   assign xi = r.x_index[tte_pkg::X_BITS-1:0];
   assign yi = r.y_index[tte_pkg::Y_BITS-1:0];
   assign x_ok = 32'(r.x_index) < tte_pkg::NX_POINTS;
   assign y_ok = 32'(r.y_index) < tte_pkg::NY_POINTS;
   assign p_ok = 32'(r.property_select) < tte_pkg::NUM_PROPERTIES;
   assign ok   = x_ok && y_ok && p_ok;
   assign addr = tte_pkg::ADDR_BITS'((32'(r.property_select) * tte_pkg::NY_POINTS
                 + 32'(yi)) * tte_pkg::NX_POINTS + 32'(xi));

   always_comb begin
      is_eval  = r.command == tte_pkg::CMD_VALUE || r.command == tte_pkg::CMD_DDX ||
                 r.command == tte_pkg::CMD_DDY;
      key_one  = (r.command == tte_pkg::CMD_DDX && r.output_kind == tte_pkg::KIND_X_KEY) ||
                 (r.command == tte_pkg::CMD_DDY && r.output_kind == tte_pkg::KIND_Y_KEY);
      key_zero = (r.command == tte_pkg::CMD_DDX && r.output_kind == tte_pkg::KIND_Y_KEY) ||
                 (r.command == tte_pkg::CMD_DDY && r.output_kind == tte_pkg::KIND_X_KEY);
      ctl_in.command   = r.command;
      ctl_in.fixed_one = is_eval && key_one;
      ctl_in.eval      = is_eval && !key_one && !key_zero && ok;
   end

   tte_store u_store (
      .clock        (clock),
      .wr_coeff_en  (accept && r.command == tte_pkg::CMD_WRITE_COEFF && ok),
      .wr_coeff_sel (r.coeff_select),
      .wr_addr      (addr),
      .wr_x_en      (accept && r.command == tte_pkg::CMD_WRITE_X && x_ok),
      .wr_y_en      (accept && r.command == tte_pkg::CMD_WRITE_Y && y_ok),
      .wr_x_addr    (xi),
      .wr_y_addr    (yi),
      .wr_data      (r.write_data),
      .rd_en        (advance),
      .rd_addr      (addr),
      .rd_x_addr    (xi),
      .rd_y_addr    (yi),
      .rd_coeff     (rd_coeff),
      .rd_x_node    (rd_x_node),
      .rd_y_node    (rd_y_node)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         m_ctl_ff <= ctl_in;
         m_xv_ff  <= r.x_value;
         m_yv_ff  <= r.y_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= accept;
      end
   end

   tte_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m_valid_ff),
      .in_ctl    (m_ctl_ff),
      .x_value   (m_xv_ff),
      .y_value   (m_yv_ff),
      .coeff     (rd_coeff),
      .x_node    (rd_x_node),
      .y_node    (rd_y_node),
      .out_valid (dp_valid),
      .out_rsp   (rsp.payload)
   );

   assign rsp.valid = dp_valid;

endmodule

// ----- rtl/tte_checker.sv -----
// ----------------------------------------------------------------------------
// Taylor table evaluator port checker
// Checks reset behavior, stall behavior and input readiness at the ports.
// ----------------------------------------------------------------------------
module tte_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tte_pkg::rsp_type rsp_payload
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Response changed while stalled.");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("Item accepted while a response is stalled.");

   a_idle_ready : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Input blocked while no response is waiting.");

endmodule

bind taylor_table_evaluator tte_checker u_tte_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

// ----- tb/sv/tb_taylor_table_evaluator.sv -----
// ----------------------------------------------------------------------------
// Taylor table evaluator testbench
// Loads node coordinates and coefficients, then checks value, d/dx and d/dy
// lookups against a predictor. The stimulus also covers key derivatives,
// saturation, out-of-range and unused codes. Both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module tb_taylor_table_evaluator;

   localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         MAX_GAP      = 17;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tte_stream_if #(.payload_type(tte_pkg::req_type)) req ();
   tte_stream_if #(.payload_type(tte_pkg::rsp_type)) rsp ();

   taylor_table_evaluator dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [31:0] coeff_table[tte_pkg::NUM_COEFFS][tte_pkg::DEPTH];
   bit          coeff_loaded[tte_pkg::NUM_COEFFS][tte_pkg::DEPTH];
   bit   [31:0] x_coord[tte_pkg::NX_POINTS];
   bit   [31:0] y_coord[tte_pkg::NY_POINTS];
   bit          x_loaded[tte_pkg::NX_POINTS];
   bit          y_loaded[tte_pkg::NY_POINTS];

   tte_pkg::req_type pending_items[$];
   tte_pkg::rsp_type expected_results[$];
   int      mismatch_count = 0;
   bit      unexpected_seen = 1'b0;
   int      send_gap = 0;
   int      take_hold = 0;
   bit      send_burst = 1'b0;
   bit      take_burst = 1'b0;

   function automatic longint clip32(longint v, inout bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> tte_pkg::FRAC_BITS;
   endfunction

   function automatic int table_addr(tte_pkg::req_type r);
      return (int'(r.property_select) * tte_pkg::NY_POINTS + int'(r.y_index))
             * tte_pkg::NX_POINTS + int'(r.x_index);
   endfunction

   // Computes the response of one item and applies its writes.
   function automatic tte_pkg::rsp_type evaluate_lookup(tte_pkg::req_type r);
      tte_pkg::rsp_type o;
      bit      flag;
      bit      in_range;
      int      a;
      longint  dx, dy, sxx, syy, sxy, sum;
      longint  c[tte_pkg::NUM_COEFFS];
      flag = 1'b0;
      sum = 0;
      in_range = r.property_select < tte_pkg::NUM_PROPERTIES;
      a = in_range ? table_addr(r) : 0;
      case (r.command)
         tte_pkg::CMD_WRITE_COEFF: begin
            if (in_range && r.coeff_select < tte_pkg::NUM_COEFFS)
               coeff_table[r.coeff_select][a] = r.write_data;
         end
         tte_pkg::CMD_WRITE_X: x_coord[r.x_index] = r.write_data;
         tte_pkg::CMD_WRITE_Y: y_coord[r.y_index] = r.write_data;
         tte_pkg::CMD_VALUE, tte_pkg::CMD_DDX, tte_pkg::CMD_DDY: begin
            if ((r.command == tte_pkg::CMD_DDX && r.output_kind == tte_pkg::KIND_X_KEY) ||
                (r.command == tte_pkg::CMD_DDY && r.output_kind == tte_pkg::KIND_Y_KEY))
            begin
               sum = longint'(tte_pkg::ONE_Q);
            end else if ((r.command == tte_pkg::CMD_DDX &&
                           r.output_kind == tte_pkg::KIND_Y_KEY) ||
                          (r.command == tte_pkg::CMD_DDY &&
                           r.output_kind == tte_pkg::KIND_X_KEY)) begin
               sum = 0;
            end else if (in_range) begin
               dx = clip32(longint'(r.x_value) - longint'($signed(x_coord[r.x_index])),
                           flag);
               dy = clip32(longint'(r.y_value) - longint'($signed(y_coord[r.y_index])),
                           flag);
               for (int k = 0; k < tte_pkg::NUM_COEFFS; k++)
                  c[k] = longint'($signed(coeff_table[k][a]));
               if (r.command == tte_pkg::CMD_VALUE) begin
                  sxx = clip32((dx * dx) >>> (tte_pkg::FRAC_BITS + 1), flag);
                  syy = clip32((dy * dy) >>> (tte_pkg::FRAC_BITS + 1), flag);
                  sxy = clip32((dx * dy) >>> tte_pkg::FRAC_BITS, flag);
                  sum = c[tte_pkg::COEFF_Z] + qmul(dx, c[tte_pkg::COEFF_DX])
                        + qmul(dy, c[tte_pkg::COEFF_DY]) + qmul(sxx, c[tte_pkg::COEFF_DXX])
                        + qmul(syy, c[tte_pkg::COEFF_DYY])
                        + qmul(sxy, c[tte_pkg::COEFF_DXY]);
               end else if (r.command == tte_pkg::CMD_DDX) begin
                  sum = c[tte_pkg::COEFF_DX] + qmul(dx, c[tte_pkg::COEFF_DXX])
                        + qmul(dy, c[tte_pkg::COEFF_DXY]);
               end else begin
                  sum = c[tte_pkg::COEFF_DY] + qmul(dy, c[tte_pkg::COEFF_DYY])
                        + qmul(dx, c[tte_pkg::COEFF_DXY]);
               end
               sum = clip32(sum, flag);
            end
         end
         default: ;
      endcase
      o.result_value = sum[31:0];
      o.saturated = flag;
      return o;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 6))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
         3, 4: return 32'($signed($urandom_range(0, 32'h3fffff)) - 32'sh1fffff);
         default: return $urandom;
      endcase
   endfunction

   function automatic tte_pkg::req_type noise_item();
      tte_pkg::req_type r;
      r = tte_pkg::req_type'($bits(tte_pkg::req_type)'({$urandom, $urandom,
                                                         $urandom, $urandom}));
      r.property_select = 3'($urandom_range(0, tte_pkg::NUM_PROPERTIES - 1));
      return r;
   endfunction

   task automatic queue_item(tte_pkg::req_type r);
      pending_items.push_back(r);
      expected_results.push_back(evaluate_lookup(r));
   endtask

   task automatic write_coeff(tte_pkg::req_type base, logic [2:0] sel, logic [31:0] data);
      tte_pkg::req_type r;
      r = noise_item();
      r.command = tte_pkg::CMD_WRITE_COEFF;
      r.x_index = base.x_index;
      r.y_index = base.y_index;
      r.property_select = base.property_select;
      r.coeff_select = sel;
      r.write_data = data;
      coeff_loaded[sel][table_addr(r)] = 1'b1;
      queue_item(r);
   endtask

   // Queues an evaluation after the writes that its reads depend on.
   task automatic queue_lookup(tte_pkg::req_type r);
      tte_pkg::req_type w;
      bool_reads: begin
         if (r.property_select >= tte_pkg::NUM_PROPERTIES) ;
         else if ((r.command == tte_pkg::CMD_DDX || r.command == tte_pkg::CMD_DDY) &&
                  (r.output_kind == tte_pkg::KIND_X_KEY ||
                   r.output_kind == tte_pkg::KIND_Y_KEY)) ;
         else begin
            if (!x_loaded[r.x_index]) begin
               w = noise_item();
               w.command = tte_pkg::CMD_WRITE_X;
               w.x_index = r.x_index;
               w.write_data = pick_word();
               x_loaded[r.x_index] = 1'b1;
               queue_item(w);
            end
            if (!y_loaded[r.y_index]) begin
               w = noise_item();
               w.command = tte_pkg::CMD_WRITE_Y;
               w.y_index = r.y_index;
               w.write_data = pick_word();
               y_loaded[r.y_index] = 1'b1;
               queue_item(w);
            end
            for (int k = 0; k < tte_pkg::NUM_COEFFS; k++)
               if (!coeff_loaded[k][table_addr(r)])
                  write_coeff(r, 3'(k), pick_word());
         end
      end
      queue_item(r);
   endtask

   function automatic tte_pkg::req_type lookup_item(logic [2:0] cmd, bit near);
      tte_pkg::req_type r;
      r = noise_item();
      r.command = cmd;
      if ($urandom_range(0, 3) != 0) begin
         r.x_index = 5'($urandom_range(0, 3));
         r.y_index = 5'($urandom_range(0, 3));
         r.property_select = 3'($urandom_range(0, 1));
      end
      if (near) begin
         r.x_value = x_coord[r.x_index] +
                     32'($signed($urandom_range(0, 32'h5ffff)) - 32'sh2ffff);
         r.y_value = y_coord[r.y_index] +
                     32'($signed($urandom_range(0, 32'h5ffff)) - 32'sh2ffff);
      end
      return r;
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!(req.valid && !req.ready)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req.payload <= pending_items.pop_front();
            req.valid <= 1'b1;
            if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
            send_gap <= send_burst ? 0 : $urandom_range(0, MAX_GAP);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Monitor and response check.
   always @(posedge clock) begin
      tte_pkg::rsp_type want;
      int      d;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            unexpected_seen = 1'b1;
            $display("response with no item outstanding: %h", rsp.payload);
         end else begin
            want = expected_results.pop_front();
            if (rsp.payload.result_value !== want.result_value ||
                rsp.payload.saturated !== want.saturated) begin
               if (mismatch_count < 10)
                  $display("mismatch: expected value %h sat %b, got value %h sat %b",
                           want.result_value, want.saturated,
                           rsp.payload.result_value, rsp.payload.saturated);
               mismatch_count++;
            end
         end
         if ($urandom_range(0, 99) == 0) take_burst = !take_burst;
         d = take_burst ? 0 : $urandom_range(0, MAX_GAP);
         take_hold <= d;
         rsp.ready <= (d == 0);
      end else if (take_hold > 0) begin
         take_hold <= take_hold - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   initial begin
      #4000000;
      $display("tb_taylor_table_evaluator: FAIL");
      $finish;
   end

   initial begin
      tte_pkg::req_type r;
      logic [2:0] cmd;
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;

      // Directed: node extremes to force clipped deltas and sums.
      r = noise_item();
      r.command = tte_pkg::CMD_WRITE_X; r.x_index = 5'd31; r.write_data = 32'h80000000;
      x_loaded[31] = 1'b1; queue_item(r);
      r.command = tte_pkg::CMD_WRITE_Y; r.y_index = 5'd0; r.write_data = 32'h7fffffff;
      y_loaded[0] = 1'b1; queue_item(r);
      r = noise_item();
      r.x_index = 5'd31; r.y_index = 5'd0;
      r.property_select = 3'(tte_pkg::NUM_PROPERTIES - 1);
      for (int k = 0; k < tte_pkg::NUM_COEFFS; k++)
         write_coeff(r, 3'(k), (k % 2) ? 32'h7fffffff : 32'h80000000);
      r.x_value = 32'h7fffffff; r.y_value = 32'h80000000;
      r.output_kind = tte_pkg::KIND_PROPERTY;
      r.command = tte_pkg::CMD_VALUE; queue_lookup(r);
      r.command = tte_pkg::CMD_DDX;   queue_lookup(r);
      r.command = tte_pkg::CMD_DDY;   r.output_kind = KIND_UNUSED; queue_lookup(r);
      r.x_value = 32'h0; r.y_value = 32'h0;
      r.command = tte_pkg::CMD_VALUE; queue_lookup(r);
      // Key derivatives and out-of-range property.
      r = noise_item();
      r.command = tte_pkg::CMD_DDX; r.output_kind = tte_pkg::KIND_X_KEY; queue_lookup(r);
      r.command = tte_pkg::CMD_DDX; r.output_kind = tte_pkg::KIND_Y_KEY; queue_lookup(r);
      r.command = tte_pkg::CMD_DDY; r.output_kind = tte_pkg::KIND_Y_KEY; queue_lookup(r);
      r.command = tte_pkg::CMD_DDY; r.output_kind = tte_pkg::KIND_X_KEY; queue_lookup(r);
      r = noise_item(); r.property_select = 3'd7; r.command = tte_pkg::CMD_VALUE;
      queue_lookup(r);
      r.command = tte_pkg::CMD_WRITE_COEFF; queue_item(r);
      r = noise_item(); r.command = tte_pkg::CMD_WRITE_COEFF; r.coeff_select = 3'd7;
      queue_item(r);
      r.coeff_select = 3'd6; queue_item(r);
      r.command = CMD_UNUSED_6; queue_item(r);
      r.command = CMD_UNUSED_7; queue_item(r);

      // Random: mostly lookups on a small node set, with writes and noise.
      for (int n = 0; n < 850; n++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               r = lookup_item(tte_pkg::CMD_WRITE_COEFF, 1'b0);
               r.write_data = pick_word();
               if (r.coeff_select < tte_pkg::NUM_COEFFS &&
                   r.property_select < tte_pkg::NUM_PROPERTIES)
                  coeff_loaded[r.coeff_select][table_addr(r)] = 1'b1;
               queue_item(r);
            end
            2: begin
               r = lookup_item(tte_pkg::CMD_WRITE_X, 1'b0);
               if ($urandom_range(0, 1)) r.command = tte_pkg::CMD_WRITE_Y;
               r.write_data = pick_word();
               if (r.command == tte_pkg::CMD_WRITE_X) x_loaded[r.x_index] = 1'b1;
               else y_loaded[r.y_index] = 1'b1;
               queue_item(r);
            end
            3: begin
               r = noise_item();
               if ($urandom_range(0, 1)) r.property_select = 3'($urandom_range(5, 7));
               else r.command = ($urandom_range(0, 1)) ? CMD_UNUSED_6 : CMD_UNUSED_7;
               if (r.command inside {tte_pkg::CMD_VALUE, tte_pkg::CMD_DDX,
                                     tte_pkg::CMD_DDY}) queue_lookup(r);
               else if (r.command == tte_pkg::CMD_WRITE_COEFF || r.command >= CMD_UNUSED_6)
                  queue_item(r);
               else begin
                  r.command = CMD_UNUSED_6;
                  queue_item(r);
               end
            end
            default: begin
               cmd = 3'($urandom_range(tte_pkg::CMD_VALUE, tte_pkg::CMD_DDY));
               queue_lookup(lookup_item(cmd, $urandom_range(0, 3) != 0));
            end
         endcase
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() > 0 || req.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && !unexpected_seen && expected_results.size() == 0)
         $display("tb_taylor_table_evaluator: PASS");
      else
         $display("tb_taylor_table_evaluator: FAIL");
      $finish;
   end

endmodule
